// File: rtl/miller_rabin_prime_test_defines.svh
`ifndef MILLER_RABIN_PRIME_TEST_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_DEFINES_SVH
// implication checked on every clock edge out of reset
`define MRPT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MRPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/mrpt_pkg.sv
package mrpt_pkg;

    localparam int NumberWidth = 64;
    localparam int BitCntWidth = $clog2(NumberWidth + 1);
    localparam int BaseCount = 12;
    localparam int BaseIdxWidth = $clog2(BaseCount);

    typedef logic [NumberWidth-1:0] word_t;
    typedef logic [BitCntWidth-1:0] bitcnt_t;
    typedef logic [BaseIdxWidth-1:0] base_idx_t;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_DOUBLE,
        MUL_ADD,
        MUL_DONE
    } mul_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_BASE,
        ST_EXP_MUL,
        ST_EXP_SQR,
        ST_EXP_NEXT,
        ST_CHECK,
        ST_SQR_LOOP,
        ST_SQR_CHECK,
        ST_RESULT
    } ctl_state_t;

    typedef struct packed {
        logic start;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_rsp_t;

    function automatic word_t base_value(base_idx_t idx);
        word_t v;
        unique case (idx)
            4'd0:    v = word_t'(2);
            4'd1:    v = word_t'(3);
            4'd2:    v = word_t'(5);
            4'd3:    v = word_t'(7);
            4'd4:    v = word_t'(11);
            4'd5:    v = word_t'(13);
            4'd6:    v = word_t'(17);
            4'd7:    v = word_t'(19);
            4'd8:    v = word_t'(23);
            4'd9:    v = word_t'(29);
            4'd10:   v = word_t'(31);
            4'd11:   v = word_t'(37);
            default: v = word_t'(2);
        endcase
        return v;
    endfunction

endpackage

// File: rtl/mrpt_if.sv
interface mrpt_in_if;
    logic valid;
    logic ready;
    logic [mrpt_pkg::NumberWidth-1:0] number;
    modport source (output valid, output number, input ready);
    modport sink (input valid, input number, output ready);
endinterface

interface mrpt_out_if;
    logic valid;
    logic ready;
    logic is_prime;
    modport source (output valid, output is_prime, input ready);
    modport sink (input valid, input is_prime, output ready);
endinterface

// File: rtl/mrpt_mulmod.sv
`include "miller_rabin_prime_test_defines.svh"

module mrpt_mulmod (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mrpt_pkg::mul_req_t    req,
    input  mrpt_pkg::word_t       x,
    input  mrpt_pkg::word_t       y,
    input  mrpt_pkg::word_t       m,
    output mrpt_pkg::mul_rsp_t    rsp,
    output mrpt_pkg::word_t       product
);

    mrpt_pkg::mul_state_t state_reg, state_next;
    mrpt_pkg::word_t acc_reg, acc_next;
    mrpt_pkg::word_t x_reg, x_next;
    mrpt_pkg::word_t y_reg, y_next;
    mrpt_pkg::word_t m_reg, m_next;
    mrpt_pkg::bitcnt_t cnt_reg, cnt_next;
    mrpt_pkg::word_t addend;
    mrpt_pkg::word_t room;
    mrpt_pkg::word_t add_res;

    always_comb
    begin
        addend  = (state_reg == mrpt_pkg::MUL_DOUBLE) ? acc_reg : x_reg;
        room    = m_reg - addend;
        add_res = (acc_reg >= room) ? (acc_reg - room) : (acc_reg + addend);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrpt_pkg::MUL_IDLE:
                if (req.start)
                begin
                    state_next = mrpt_pkg::MUL_DOUBLE;
                end
            mrpt_pkg::MUL_DOUBLE:
                if (y_reg[mrpt_pkg::NumberWidth-1])
                begin
                    state_next = mrpt_pkg::MUL_ADD;
                end
                else if (cnt_reg == mrpt_pkg::bitcnt_t'(1))
                begin
                    state_next = mrpt_pkg::MUL_DONE;
                end
            mrpt_pkg::MUL_ADD:
                if (cnt_reg == mrpt_pkg::bitcnt_t'(1))
                begin
                    state_next = mrpt_pkg::MUL_DONE;
                end
                else
                begin
                    state_next = mrpt_pkg::MUL_DOUBLE;
                end
            mrpt_pkg::MUL_DONE:
                state_next = mrpt_pkg::MUL_IDLE;
            default:
                state_next = mrpt_pkg::MUL_IDLE;
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        m_next   = m_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            mrpt_pkg::MUL_IDLE:
                if (req.start)
                begin
                    acc_next = '0;
                    x_next   = x;
                    y_next   = y;
                    m_next   = m;
                    cnt_next = mrpt_pkg::bitcnt_t'(mrpt_pkg::NumberWidth);
                end
            mrpt_pkg::MUL_DOUBLE:
            begin
                acc_next = add_res;
                if (!y_reg[mrpt_pkg::NumberWidth-1])
                begin
                    y_next   = y_reg << 1;
                    cnt_next = cnt_reg - mrpt_pkg::bitcnt_t'(1);
                end
            end
            mrpt_pkg::MUL_ADD:
            begin
                acc_next = add_res;
                y_next   = y_reg << 1;
                cnt_next = cnt_reg - mrpt_pkg::bitcnt_t'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrpt_pkg::MUL_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
    end

    assign rsp.busy = (state_reg != mrpt_pkg::MUL_IDLE);
    assign rsp.done = (state_reg == mrpt_pkg::MUL_DONE);
    assign product  = acc_reg;

    `MRPT_ASSERT_NEXT(a_done_idle, state_reg == mrpt_pkg::MUL_DONE,
        state_reg == mrpt_pkg::MUL_IDLE)
    `MRPT_ASSERT_IMP(a_add_count, state_reg == mrpt_pkg::MUL_ADD,
        cnt_reg != mrpt_pkg::bitcnt_t'(0))
    `MRPT_ASSERT_NEXT(a_start, state_reg == mrpt_pkg::MUL_IDLE && req.start,
        state_reg == mrpt_pkg::MUL_DOUBLE)

endmodule

// File: rtl/miller_rabin_prime_test.sv
// channel | dir | payload          | handshake
// in_ch   | in  | number[63:0]     | valid/ready
// out_ch  | out | is_prime         | valid/ready
// One number is tested at a time; ready is high only while idle.
// Each modular product runs on one shared double-and-add unit; a number
// needs up to about 12 * 125 products, far fewer when an early base
// proves it composite.
// Reset (async, active low) returns the block to idle with no result held.
// A result holds in out_ch until taken; the next number is taken after that.
`include "miller_rabin_prime_test_defines.svh"

module miller_rabin_prime_test (
    input  logic        clk,
    input  logic        rst_n,
    mrpt_in_if.sink     in_ch,
    mrpt_out_if.source  out_ch
);

    mrpt_pkg::ctl_state_t state_reg, state_next;
    mrpt_pkg::word_t n_reg, n_next;
    mrpt_pkg::word_t d_reg, d_next;
    mrpt_pkg::word_t e_reg, e_next;
    mrpt_pkg::word_t b_reg, b_next;
    mrpt_pkg::word_t x_reg, x_next;
    mrpt_pkg::bitcnt_t s_reg, s_next;
    mrpt_pkg::bitcnt_t r_reg, r_next;
    mrpt_pkg::base_idx_t idx_reg, idx_next;
    logic prime_reg, prime_next;
    logic pend_reg, pend_next;
    mrpt_pkg::mul_req_t mreq;
    mrpt_pkg::mul_rsp_t mrsp;
    mrpt_pkg::word_t mx, my, mprod, nm1, base_a;

    assign nm1    = n_reg - mrpt_pkg::word_t'(1);
    assign base_a = mrpt_pkg::base_value(idx_reg);

    mrpt_mulmod u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .x       (mx),
        .y       (my),
        .m       (n_reg),
        .rsp     (mrsp),
        .product (mprod)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrpt_pkg::ST_IDLE:
                if (in_ch.valid && in_ch.ready)
                begin
                    state_next = mrpt_pkg::ST_SPLIT;
                end
            mrpt_pkg::ST_SPLIT:
                if (n_reg < mrpt_pkg::word_t'(4))
                begin
                    state_next = mrpt_pkg::ST_RESULT;
                end
                else if (d_reg[0])
                begin
                    state_next = mrpt_pkg::ST_BASE;
                end
            mrpt_pkg::ST_BASE:
                if (n_reg == base_a)
                begin
                    state_next = mrpt_pkg::ST_RESULT;
                end
                else
                begin
                    state_next = mrpt_pkg::ST_EXP_NEXT;
                end
            mrpt_pkg::ST_EXP_NEXT:
                if (e_reg == '0)
                begin
                    state_next = mrpt_pkg::ST_CHECK;
                end
                else if (e_reg[0])
                begin
                    state_next = mrpt_pkg::ST_EXP_MUL;
                end
                else
                begin
                    state_next = mrpt_pkg::ST_EXP_SQR;
                end
            mrpt_pkg::ST_EXP_MUL:
                if (mrsp.done)
                begin
                    state_next = mrpt_pkg::ST_EXP_NEXT;
                end
            mrpt_pkg::ST_EXP_SQR:
                if (mrsp.done)
                begin
                    state_next = mrpt_pkg::ST_EXP_NEXT;
                end
            mrpt_pkg::ST_CHECK:
                if (x_reg == mrpt_pkg::word_t'(1) || x_reg == nm1)
                begin
                    state_next = (idx_reg == mrpt_pkg::base_idx_t'(mrpt_pkg::BaseCount - 1))
                                 ? mrpt_pkg::ST_RESULT : mrpt_pkg::ST_BASE;
                end
                else
                begin
                    state_next = mrpt_pkg::ST_SQR_CHECK;
                end
            mrpt_pkg::ST_SQR_CHECK:
                if (r_reg >= s_reg)
                begin
                    state_next = mrpt_pkg::ST_RESULT;
                end
                else
                begin
                    state_next = mrpt_pkg::ST_SQR_LOOP;
                end
            mrpt_pkg::ST_SQR_LOOP:
                if (mrsp.done)
                begin
                    if (mprod == nm1)
                    begin
                        state_next = (idx_reg ==
                                      mrpt_pkg::base_idx_t'(mrpt_pkg::BaseCount - 1))
                                     ? mrpt_pkg::ST_RESULT : mrpt_pkg::ST_BASE;
                    end
                    else
                    begin
                        state_next = mrpt_pkg::ST_SQR_CHECK;
                    end
                end
            mrpt_pkg::ST_RESULT:
                if (!pend_reg || out_ch.ready)
                begin
                    state_next = mrpt_pkg::ST_IDLE;
                end
            default:
                state_next = mrpt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        n_next     = n_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        b_next     = b_reg;
        x_next     = x_reg;
        s_next     = s_reg;
        r_next     = r_reg;
        idx_next   = idx_reg;
        prime_next = prime_reg;
        pend_next  = pend_reg;
        mreq.start = 1'b0;
        mx         = x_reg;
        my         = b_reg;
        if (pend_reg && out_ch.ready)
        begin
            pend_next = 1'b0;
        end
        unique case (state_reg)
            mrpt_pkg::ST_IDLE:
                if (in_ch.valid && in_ch.ready)
                begin
                    n_next   = in_ch.number;
                    d_next   = in_ch.number - mrpt_pkg::word_t'(1);
                    s_next   = '0;
                    idx_next = '0;
                end
            mrpt_pkg::ST_SPLIT:
                if (n_reg < mrpt_pkg::word_t'(4))
                begin
                    prime_next = (n_reg == mrpt_pkg::word_t'(2))
                              || (n_reg == mrpt_pkg::word_t'(3));
                end
                else if (!d_reg[0])
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + mrpt_pkg::bitcnt_t'(1);
                end
            mrpt_pkg::ST_BASE:
            begin
                prime_next = 1'b1;
                e_next     = d_reg;
                b_next     = base_a;
                x_next     = mrpt_pkg::word_t'(1);
                r_next     = mrpt_pkg::bitcnt_t'(1);
            end
            mrpt_pkg::ST_EXP_NEXT:
                if (e_reg != '0)
                begin
                    mreq.start = 1'b1;
                    if (e_reg[0])
                    begin
                        mx = x_reg;
                        my = b_reg;
                    end
                    else
                    begin
                        mx = b_reg;
                        my = b_reg;
                    end
                end
            mrpt_pkg::ST_EXP_MUL:
                if (mrsp.done)
                begin
                    x_next = mprod;
                    e_next = {e_reg[mrpt_pkg::NumberWidth-1:1], 1'b0};
                end
            mrpt_pkg::ST_EXP_SQR:
                if (mrsp.done)
                begin
                    b_next = mprod;
                    e_next = e_reg >> 1;
                end
            mrpt_pkg::ST_CHECK:
                if (x_reg == mrpt_pkg::word_t'(1) || x_reg == nm1)
                begin
                    idx_next = idx_reg + mrpt_pkg::base_idx_t'(1);
                end
            mrpt_pkg::ST_SQR_CHECK:
                if (r_reg >= s_reg)
                begin
                    prime_next = 1'b0;
                end
                else
                begin
                    mreq.start = 1'b1;
                    mx         = x_reg;
                    my         = x_reg;
                end
            mrpt_pkg::ST_SQR_LOOP:
                if (mrsp.done)
                begin
                    x_next = mprod;
                    r_next = r_reg + mrpt_pkg::bitcnt_t'(1);
                    if (mprod == nm1)
                    begin
                        idx_next = idx_reg + mrpt_pkg::base_idx_t'(1);
                    end
                end
            mrpt_pkg::ST_RESULT:
                if (!pend_reg || out_ch.ready)
                begin
                    pend_next = 1'b1;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrpt_pkg::ST_IDLE;
            pend_reg  <= 1'b0;
            idx_reg   <= '0;
            s_reg     <= '0;
            r_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
            s_reg     <= s_next;
            r_reg     <= r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
        b_reg     <= b_next;
        x_reg     <= x_next;
        prime_reg <= prime_next;
    end

    assign in_ch.ready     = (state_reg == mrpt_pkg::ST_IDLE) && !pend_reg;
    assign out_ch.valid    = pend_reg;
    assign out_ch.is_prime = prime_reg;

    `MRPT_ASSERT_IMP(a_mul_quiet, state_reg == mrpt_pkg::ST_IDLE, !mrsp.busy)
    `MRPT_ASSERT_IMP(a_ready_excl, in_ch.ready, !out_ch.valid)
    `MRPT_ASSERT_NEXT(a_take, in_ch.valid && in_ch.ready,
        state_reg == mrpt_pkg::ST_SPLIT)
    `MRPT_ASSERT_IMP(a_base_range, state_reg == mrpt_pkg::ST_BASE,
        idx_reg < mrpt_pkg::base_idx_t'(mrpt_pkg::BaseCount))

endmodule

// File: bench/miller_rabin_prime_test_tb.sv
module miller_rabin_prime_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 2000000;
    localparam int DrainCycles = 50;

    logic clk;
    logic rst_n;
    mrpt_in_if in_ch();
    mrpt_out_if out_ch();

    miller_rabin_prime_test dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    bit verdict_q[$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic mrpt_pkg::word_t mul_mod(mrpt_pkg::word_t x, mrpt_pkg::word_t y,
                                                mrpt_pkg::word_t m);
        logic [2*mrpt_pkg::NumberWidth-1:0] prod;
        prod = {{mrpt_pkg::NumberWidth{1'b0}}, x} * {{mrpt_pkg::NumberWidth{1'b0}}, y};
        return mrpt_pkg::word_t'(prod % {{mrpt_pkg::NumberWidth{1'b0}}, m});
    endfunction

    function automatic mrpt_pkg::word_t pow_mod(mrpt_pkg::word_t b, mrpt_pkg::word_t e,
                                                mrpt_pkg::word_t m);
        mrpt_pkg::word_t acc;
        acc = mrpt_pkg::word_t'(1) % m;
        while (e != 0)
        begin
            if (e[0])
                acc = mul_mod(acc, b, m);
            b = mul_mod(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic bit predict_prime(mrpt_pkg::word_t n);
        mrpt_pkg::word_t d;
        mrpt_pkg::word_t x;
        mrpt_pkg::word_t a;
        int s;
        bit witness;
        mrpt_pkg::word_t bases[mrpt_pkg::BaseCount] = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11,
            64'd13, 64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37};
        if (n < 4)
            return n == 2 || n == 3;
        d = n - 1;
        s = 0;
        while (!d[0])
        begin
            d = d >> 1;
            s++;
        end
        foreach (bases[i])
        begin
            a = bases[i];
            if (n == a)
                return 1'b1;
            x = pow_mod(a % n, d, n);
            witness = !(x == 1 || x == n - 1);
            for (int r = 1; r < s && witness; r++)
            begin
                x = mul_mod(x, x, n);
                if (x == n - 1)
                    witness = 1'b0;
            end
            if (witness)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // hold valid across back-to-back transfers; drop it only for a gap
    task automatic send_number(mrpt_pkg::word_t n);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.number <= n;
        do
            @(posedge clk);
        while (!in_ch.ready);
        verdict_q = {verdict_q, predict_prime(n)};
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch("result with no number pending");
                else if (out_ch.is_prime !== verdict_q[0])
                begin
                    report_mismatch($sformatf("is_prime %b, expected %b",
                        out_ch.is_prime, verdict_q[0]));
                    void'(verdict_q.pop_front());
                end
                else
                    void'(verdict_q.pop_front());
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed();
        mrpt_pkg::word_t list[$] = '{
            64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd37, 64'd41,
            64'd561, 64'd2047, 64'd1373653, 64'd25326001, 64'd3215031751,
            64'd4294967291, 64'd341550071728321, 64'd3825123056546413051,
            64'h1FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5,
            64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
            64'h8000_0000_0000_0001, 64'hAAAA_AAAA_AAAA_AAAB
        };
        send_idle_pct = 0;
        recv_stall_pct = 0;
        foreach (list[i])
            send_number(list[i]);
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        mrpt_pkg::word_t n;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
                n = {$urandom, $urandom};
            else if ($urandom_range(3) == 0)
                n = mrpt_pkg::word_t'($urandom_range(1000, 2))
                  * mrpt_pkg::word_t'($urandom_range(1000, 2));
            else
                n = mrpt_pkg::word_t'($urandom_range(4095));
            send_number(n);
        end
    endtask

    task automatic test_pause_until_drained();
        drain_results();
        send_number(64'd97);
        drain_results();
        send_number(64'd91);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.number = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(0, 0, 20);
        test_random_phase(55, 0, 20);
        test_pause_until_drained();
        test_random_phase(0, 55, 20);
        test_random_phase(27, 27, 20);
        test_random_phase(0, 0, 10);
        drain_results();
        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0 && verdict_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/mrpt_pkg.sv
rtl/mrpt_if.sv
rtl/mrpt_mulmod.sv
rtl/miller_rabin_prime_test.sv
bench/miller_rabin_prime_test_tb.sv
